// ----- rtl/core/mqd_pkg.sv -----
// ============================================================================
// mqd_pkg
// Shared types, codes and constants of the multi-queue dispatcher core.
// ============================================================================
package mqd_pkg;

  // Default build sizes.
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_WIDTH_DEF   = 32;

  // Field widths of the channels.
  localparam int EVT_TAG_W   = 32;
  localparam int QSEL_W      = 3;
  localparam int FILL_W      = 5;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_QUEUES_W = 4;
  localparam int CFG_POLICY_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_QUEUES_IN_USE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_POLICY = 1'd1;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Balance policies; the unused code behaves as round robin.
  localparam logic [CFG_POLICY_W-1:0] POL_ROUND_ROBIN = 2'd0;
  localparam logic [CFG_POLICY_W-1:0] POL_BALANCED    = 2'd1;
  localparam logic [CFG_POLICY_W-1:0] POL_RANDOM      = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Queue selection path of an accepted item.
  localparam logic [1:0] PATH_DIRECT   = 2'd0;
  localparam logic [1:0] PATH_RR       = 2'd1;
  localparam logic [1:0] PATH_BALANCED = 2'd2;
  localparam logic [1:0] PATH_RANDOM   = 2'd3;

  // Random selection: 16-bit LFSR and its remainder unit.
  localparam int               LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam int               MOD_BITS_PER_STEP = 4;
  localparam int               MOD_STEPS = LFSR_W / MOD_BITS_PER_STEP;

  typedef struct packed {
    logic                 opcode;
    logic [EVT_TAG_W-1:0] event_tag;
    logic                 single_threaded;
    logic [QSEL_W-1:0]    target_queue;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [QSEL_W-1:0]    chosen_queue;
    logic [EVT_TAG_W-1:0] popped_tag;
    logic [FILL_W-1:0]    queue_fill;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic bal_load;
    logic bal_pick;
    logic rand_start;
    logic take_rem;
    logic access;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] path;
    logic       mod_done;
  } sts_t;

endpackage

// ----- rtl/core/multi_queue_load_balancing_dispatcher_core.sv -----
// ============================================================================
// multi_queue_load_balancing_dispatcher_core
// Per-worker event FIFOs with round robin, balanced and random dispatch.
// ============================================================================
// Request channel (req_valid, req_stall, req): an enqueue stores an event tag
// in a worker queue picked by the balance policy (queue 0 when flagged single
// threaded or when one queue is in use); a dequeue pops the named queue.
// Response channel (rsp_valid, rsp_stall, rsp): one result per request, with
// status, queue, popped tag and the queue's fill after the operation.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
// is the number of queues in use, index 1 the balance policy. Always ready;
// write only while no request is in flight.
// One request occupies the core through its result step: a dequeue, single
// threaded or round robin enqueue goes straight to the access step, a balanced
// one first does two count lookups and a random one first waits on the remainder
// unit (four bits of the LFSR value a cycle). The tag memory read is registered.
// A new request is taken while the previous result still waits on a stalled
// response channel; it holds in its last step until the result moves on.
// Reset empties all queues, restores one queue in use, round robin and the
// LFSR seed; tag memory contents are not cleared.
// ============================================================================
module multi_queue_load_balancing_dispatcher_core #(
  parameter int NUM_QUEUES  = mqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqd_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = mqd_pkg::TAG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  mqd_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output mqd_pkg::rsp_t                   rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mqd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mqd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mqd_pkg::cmd_t cmd;
  mqd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mqd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/core/mqd_mod_unit.sv -----
// ============================================================================
// mqd_mod_unit
// Remainder of a 16-bit value by a small divisor, four dividend bits a cycle.
// ============================================================================
module mqd_mod_unit #(
  parameter int NW = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mqd_pkg::LFSR_W-1:0]  dividend,
  input  logic [NW-1:0]               divisor,
  output logic                        done,
  output logic [NW-1:0]               rem
);

  localparam int CNT_W = (mqd_pkg::MOD_STEPS > 1) ? $clog2(mqd_pkg::MOD_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(mqd_pkg::MOD_STEPS - 1);

  logic [mqd_pkg::LFSR_W-1:0] shreg;
  logic [NW-1:0]              div_r;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [NW-1:0]              rem_next;

  // Restoring remainder steps on the top bits of the shift register.
  always_comb begin
    logic [NW:0] v;
    logic [NW-1:0] r;
    r = rem;
    for (int k = 0; k < mqd_pkg::MOD_BITS_PER_STEP; k++) begin
      v = {r, shreg[mqd_pkg::LFSR_W-1-k]};
      if (v >= {1'b0, div_r}) begin
        v = v - {1'b0, div_r};
      end
      r = v[NW-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << mqd_pkg::MOD_BITS_PER_STEP;
      rem   <= rem_next;
    end
  end

endmodule

// ----- rtl/core/mqd_datapath.sv -----
// ============================================================================
// mqd_datapath
// Queue storage, pointers, counts, balance policy state and result register.
// ============================================================================
module mqd_datapath #(
  parameter int NUM_QUEUES  = mqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqd_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = mqd_pkg::TAG_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mqd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mqd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  mqd_pkg::req_t                    req,
  output mqd_pkg::rsp_t                    rsp,
  input  mqd_pkg::cmd_t                    cmd,
  output mqd_pkg::sts_t                    sts
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NW = $clog2(NUM_QUEUES + 1);
  localparam int XW = NW + 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] ROW_SIZE = AW'(QUEUE_DEPTH);

  // Configuration.
  logic [mqd_pkg::CFG_QUEUES_W-1:0] queues_in_use;
  logic [mqd_pkg::CFG_POLICY_W-1:0] balance_policy;

  // Queue state.
  logic [TAG_WIDTH-1:0] tag_mem [0:NUM_QUEUES*QUEUE_DEPTH-1];
  logic [TAG_WIDTH-1:0] rdata;
  logic [PW-1:0]        head [NUM_QUEUES];
  logic [PW-1:0]        tail [NUM_QUEUES];
  logic [CW-1:0]        occ  [NUM_QUEUES];
  logic [QW-1:0]        sel;
  logic [mqd_pkg::LFSR_W-1:0] lfsr;

  // Item in flight.
  logic                 is_deq;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [mqd_pkg::QSEL_W-1:0] target_r;
  logic                 in_range;
  logic [QW-1:0]        q_idx;
  logic [QW-1:0]        j1_r;
  logic [QW-1:0]        j2_r;
  logic [CW-1:0]        occ_j1;
  logic [mqd_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]        res_fill;

  // Combinational selection terms.
  logic [4:0]           cfg_x;
  logic [4:0]           n_wide;
  logic [NW-1:0]        n;
  logic [XW-1:0]        n_x;
  logic [XW-1:0]        s_x;
  logic [XW-1:0]        j1_x;
  logic [XW-1:0]        j2_x;
  logic [4:0]           target_x;
  logic                 direct;
  logic [1:0]           path;
  logic [mqd_pkg::LFSR_W-1:0] lfsr_next;
  logic                 mod_done;
  logic [NW-1:0]        mod_rem;

  logic [CW-1:0]        occ_q;
  logic [PW-1:0]        head_q;
  logic [PW-1:0]        tail_q;
  logic [AW-1:0]        mem_addr;
  logic                 full_q;
  logic                 empty_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use  <= mqd_pkg::CFG_QUEUES_W'(1);
      balance_policy <= mqd_pkg::POL_ROUND_ROBIN;
    end else if (cfg_we) begin
      case (cfg_index)
        mqd_pkg::REG_QUEUES_IN_USE:  queues_in_use  <= cfg_data;
        mqd_pkg::REG_BALANCE_POLICY: balance_policy <= cfg_data[mqd_pkg::CFG_POLICY_W-1:0];
        default: ;
      endcase
    end
  end

  // A count of zero means one queue; counts above the build size are clipped.
  always_comb begin
    cfg_x = 5'(queues_in_use);
    if (cfg_x == 5'd0) begin
      n_wide = 5'd1;
    end else if (cfg_x > 5'(NUM_QUEUES)) begin
      n_wide = 5'(NUM_QUEUES);
    end else begin
      n_wide = cfg_x;
    end
    n   = NW'(n_wide);
    n_x = XW'(n);

    // A selection left over from a larger count restarts at queue 0.
    s_x  = (XW'(sel) >= n_x) ? '0 : XW'(sel);
    j1_x = s_x + XW'(1);
    if (j1_x >= n_x) begin
      j1_x = j1_x - n_x;
    end
    j2_x = s_x + XW'(2);
    if (j2_x >= n_x) begin
      j2_x = j2_x - n_x;
    end

    target_x = 5'(req.target_queue);
    direct   = req.single_threaded || (n == NW'(1));
    if (req.opcode == mqd_pkg::OP_DEQUEUE || direct) begin
      path = mqd_pkg::PATH_DIRECT;
    end else begin
      case (balance_policy)
        mqd_pkg::POL_BALANCED: path = mqd_pkg::PATH_BALANCED;
        mqd_pkg::POL_RANDOM:   path = mqd_pkg::PATH_RANDOM;
        default:               path = mqd_pkg::PATH_RR;
      endcase
    end

    lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[mqd_pkg::LFSR_W-1:1]};
  end

  assign sts.path     = path;
  assign sts.mod_done = mod_done;

  mqd_mod_unit #(
    .NW(NW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rand_start),
    .dividend (lfsr_next),
    .divisor  (n),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // One queue is looked at per cycle in the access step.
  always_comb begin
    occ_q    = occ[q_idx];
    head_q   = head[q_idx];
    tail_q   = tail[q_idx];
    full_q   = (occ_q == FULL);
    empty_q  = !in_range || (occ_q == '0);
    mem_addr = AW'(q_idx) * ROW_SIZE + AW'(is_deq ? head_q : tail_q);
  end

  // Selection state and the item in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel  <= '0;
      lfsr <= mqd_pkg::LFSR_SEED;
    end else begin
      if (cmd.accept && path == mqd_pkg::PATH_RR) begin
        sel <= j1_x[QW-1:0];
      end
      if (cmd.bal_pick) begin
        sel <= (occ_j1 < occ[j2_r]) ? j1_r : j2_r;
      end
      if (cmd.rand_start) begin
        lfsr <= lfsr_next;
      end
      if (cmd.take_rem) begin
        sel <= mod_rem[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_deq   <= (req.opcode == mqd_pkg::OP_DEQUEUE);
      tag_r    <= TAG_WIDTH'(req.event_tag);
      target_r <= req.target_queue;
      j1_r     <= j1_x[QW-1:0];
      j2_r     <= j2_x[QW-1:0];
      if (req.opcode == mqd_pkg::OP_DEQUEUE) begin
        q_idx    <= target_x[QW-1:0];
        in_range <= (target_x < 5'(NUM_QUEUES));
      end else begin
        q_idx    <= direct ? '0 : s_x[QW-1:0];
        in_range <= 1'b1;
      end
    end
    if (cmd.bal_load) begin
      occ_j1 <= occ[j1_r];
    end
    if (cmd.take_rem) begin
      q_idx <= mod_rem[QW-1:0];
    end
  end

  // Pointers and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        occ[i]  <= '0;
      end
    end else if (cmd.access) begin
      if (!is_deq && !full_q) begin
        tail[q_idx] <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
        occ[q_idx]  <= occ_q + 1'b1;
      end else if (is_deq && !empty_q) begin
        head[q_idx] <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
        occ[q_idx]  <= occ_q - 1'b1;
      end
    end
  end

  // Tag storage, one port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.access && !is_deq && !full_q) begin
      tag_mem[mem_addr] <= tag_r;
    end
    if (cmd.access && is_deq && !empty_q) begin
      rdata <= tag_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      if (!is_deq) begin
        res_status <= full_q ? mqd_pkg::ST_DROPPED : mqd_pkg::ST_ENQUEUED;
        res_fill   <= full_q ? occ_q : occ_q + 1'b1;
      end else begin
        res_status <= empty_q ? mqd_pkg::ST_EMPTY : mqd_pkg::ST_DEQUEUED;
        res_fill   <= empty_q ? '0 : occ_q - 1'b1;
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.status       <= res_status;
      rsp.chosen_queue <= is_deq ? target_r : mqd_pkg::QSEL_W'(q_idx);
      rsp.popped_tag   <= (res_status == mqd_pkg::ST_DEQUEUED) ?
                          mqd_pkg::EVT_TAG_W'(rdata) : '0;
      rsp.queue_fill   <= mqd_pkg::FILL_W'(res_fill);
    end
  end

endmodule

// ----- rtl/core/mqd_ctrl.sv -----
// ============================================================================
// mqd_ctrl
// Sequencer for one dispatch item and the output valid flag.
// ============================================================================
module mqd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mqd_pkg::cmd_t cmd,
  input  mqd_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BAL1   = 3'd1;
  localparam logic [2:0] S_BAL2   = 3'd2;
  localparam logic [2:0] S_RAND   = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_ACCESS = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (sts.path)
            mqd_pkg::PATH_BALANCED: state_next = S_BAL1;
            mqd_pkg::PATH_RANDOM:   state_next = S_RAND;
            default:                state_next = S_ACCESS;
          endcase
        end
      end
      S_BAL1: begin
        cmd.bal_load = 1'b1;
        state_next   = S_BAL2;
      end
      S_BAL2: begin
        cmd.bal_pick = 1'b1;
        state_next   = S_ACCESS;
      end
      S_RAND: begin
        cmd.rand_start = 1'b1;
        state_next     = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.take_rem = 1'b1;
          state_next   = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The read data is ready now; wait only for room in the result register.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("controller took a second item right after a transfer");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while holding a stalled result");

  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    sts.mod_done |-> (state == S_MOD))
    else $error("remainder finished outside the random selection wait");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCESS) |=> (state == S_DONE))
    else $error("access step not followed by result step");

endmodule
